// ===== hw/rtl/owdk_pkg.sv =====
// Package for the omni wheel drive kinematics block.
// Holds widths, fixed-point constants and the stage load struct.
// No dependencies.
package owdk_pkg;

  localparam int NUM_WHEELS = 3;
  localparam int NUM_STAGES = 6;

  localparam int IN_W   = 16;
  localparam int RATE_W = 26;  // exact wheel rate integers, +-728 * 2^15 worst case
  localparam int REV_W  = 25;  // rev/s in Q.24, signed
  localparam int TERM_W = 48;  // one polynomial term in Q.40
  localparam int SUM_W  = 50;  // polynomial sum in Q.40
  localparam int DRV_SH = 40;
  localparam int DRV_W  = 8;
  localparam int D_W    = SUM_W - DRV_SH;
  localparam int LIM_W  = 32;
  localparam int REV_FRAC = 24;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic signed [REV_W-1:0]  rev_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [DRV_W-1:0]         drive_t;

  // Wheel direction weights, scaled by ten thousandths over twenty.
  localparam rate_t K_500 = rate_t'(500);
  localparam rate_t K_433 = rate_t'(433);
  localparam rate_t K_250 = rate_t'(250);
  localparam rate_t K_45  = rate_t'(45);

  // round(2^32 / (20 pi)), converts rate units to rev/s.
  localparam logic signed [27:0] INV_20PI = 28'sd68356528;

  // Cubic servo calibration, Q.16.
  localparam logic signed [22:0] COEF_A = 23'sd2608680;
  localparam logic signed [22:0] COEF_B = 23'sd826298;
  localparam logic signed [22:0] COEF_C = 23'sd1449637;
  localparam sum_t COEF_D_Q40 = sum_t'(8416539) <<< REV_FRAC;

  localparam logic signed [D_W-1:0] D_MAX = D_W'(255);

  // One load enable for each pipeline stage.
  typedef struct packed {
    logic load_rate;
    logic load_scale;
    logic load_square;
    logic load_cube;
    logic load_terms;
    logic load_sum;
  } stage_ctl_t;

endpackage

// ===== hw/rtl/owdk_cmd_if.sv =====
// Command channel: one body velocity item per handshake.
// Depends on owdk_pkg for the field width.
interface owdk_cmd_if import owdk_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] velocity_x;
  logic signed [IN_W-1:0] velocity_y;
  logic signed [IN_W-1:0] turn_rate;

  modport source (output valid, output velocity_x, output velocity_y, output turn_rate,
                  input ready);
  modport sink   (input valid, input velocity_x, input velocity_y, input turn_rate,
                  output ready);
endinterface

// ===== hw/rtl/owdk_drive_if.sv =====
// Drive channel: three servo drive values and the infeasible flag per item.
// Depends on owdk_pkg for the field type.
interface owdk_drive_if import owdk_pkg::*;;
  logic   valid;
  logic   ready;
  drive_t wheel_one_drive;
  drive_t wheel_two_drive;
  drive_t wheel_three_drive;
  logic   infeasible;

  modport source (output valid, output wheel_one_drive, output wheel_two_drive,
                  output wheel_three_drive, output infeasible, input ready);
  modport sink   (input valid, input wheel_one_drive, input wheel_two_drive,
                  input wheel_three_drive, input infeasible, output ready);
endinterface

// ===== hw/rtl/owdk_rate_stage.sv =====
// First two pipeline stages: exact wheel rates, limit check, scaling to rev/s.
// Depends on owdk_pkg.
module owdk_rate_stage import owdk_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                   clk,
  input  stage_ctl_t             ctl,
  input  logic signed [IN_W-1:0] velocity_x,
  input  logic signed [IN_W-1:0] velocity_y,
  input  logic signed [IN_W-1:0] turn_rate,
  output rev_t                   x_r [NUM_WHEELS],
  output logic [NUM_WHEELS-1:0]  zero_r,
  output logic                   bad_r
);

  localparam logic signed [LIM_W-1:0] LIM = LIM_W'(60) <<< FRAC_BITS;
  localparam int SCALE_SH = FRAC_BITS + 8;
  localparam int PROD_W   = RATE_W + 28;

  rate_t r_nxt [NUM_WHEELS];
  rate_t r_r   [NUM_WHEELS];
  rate_t vx, vy, w;

  logic signed [LIM_W-1:0]  rl   [NUM_WHEELS];
  logic signed [PROD_W-1:0] prod [NUM_WHEELS];
  rev_t                     x_nxt [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]    over, at_lim;
  logic [NUM_WHEELS-1:0]    zero_nxt;

  always_comb begin
    vx = rate_t'(velocity_x);
    vy = rate_t'(velocity_y);
    w  = rate_t'(turn_rate);
    r_nxt[0] = K_45 * w - K_500 * vx;
    r_nxt[1] = K_250 * vx - K_433 * vy + K_45 * w;
    r_nxt[2] = K_433 * vx + K_250 * vy + K_45 * w;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_rate) begin
      r_r <= r_nxt;
    end
  end

  // A rate exactly at the limit is still feasible but drives that wheel with 0.
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      rl[i]     = LIM_W'(r_r[i]);
      over[i]   = (rl[i] > LIM) || (rl[i] < -LIM);
      at_lim[i] = (rl[i] == LIM) || (rl[i] == -LIM);
      prod[i]   = r_r[i] * INV_20PI;
      x_nxt[i]  = rev_t'(prod[i] >>> SCALE_SH);
    end
    zero_nxt = at_lim | {NUM_WHEELS{|over}};
  end

  always_ff @(posedge clk) begin
    if (ctl.load_scale) begin
      x_r    <= x_nxt;
      zero_r <= zero_nxt;
      bad_r  <= |over;
    end
  end

endmodule

// ===== hw/rtl/owdk_cubic.sv =====
// Stages three to six for one wheel: square, cube, terms, sum and clamp.
// Depends on owdk_pkg.
module owdk_cubic import owdk_pkg::*; (
  input  logic       clk,
  input  stage_ctl_t ctl,
  input  rev_t       x_in,
  input  logic       zero_in,
  output drive_t     drive_r
);

  logic signed [2*REV_W-1:0] sq, cu;
  rev_t  x_s3_r, x2_s3_r, x_s4_r, x2_s4_r, x3_s4_r;
  logic  z_s3_r, z_s4_r, z_s5_r;
  term_t pa, pb, pc;
  term_t pa_r, pb_r, pc_r;
  sum_t  sum;
  logic signed [D_W-1:0] d;
  drive_t drive_nxt;

  assign sq = x_in * x_in;

  always_ff @(posedge clk) begin
    if (ctl.load_square) begin
      x_s3_r  <= x_in;
      x2_s3_r <= rev_t'(sq >>> REV_FRAC);
      z_s3_r  <= zero_in;
    end
  end

  assign cu = x2_s3_r * x_s3_r;

  always_ff @(posedge clk) begin
    if (ctl.load_cube) begin
      x_s4_r  <= x_s3_r;
      x2_s4_r <= x2_s3_r;
      x3_s4_r <= rev_t'(cu >>> REV_FRAC);
      z_s4_r  <= z_s3_r;
    end
  end

  assign pa = x3_s4_r * COEF_A;
  assign pb = x2_s4_r * COEF_B;
  assign pc = x_s4_r * COEF_C;

  always_ff @(posedge clk) begin
    if (ctl.load_terms) begin
      pa_r   <= pa;
      pb_r   <= pb;
      pc_r   <= pc;
      z_s5_r <= z_s4_r;
    end
  end

  always_comb begin
    sum = sum_t'(pa_r) - sum_t'(pb_r) + sum_t'(pc_r) + COEF_D_Q40;
    d   = D_W'(sum >>> DRV_SH);
    priority if (z_s5_r) begin
      drive_nxt = '0;
    end else if (d < 0) begin
      drive_nxt = '0;
    end else if (d > D_MAX) begin
      drive_nxt = '1;
    end else begin
      drive_nxt = d[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

// ===== hw/rtl/omni_wheel_drive_kinematics_top.sv =====
// Omni wheel drive kinematics; throughput one item per cycle while out_drv is ready.
// Each stage advances when it is empty or the next one moves.
// The output register is the last stage, so input is taken while a result waits if a stage is empty.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
// Depends on owdk_pkg, owdk_cmd_if, owdk_drive_if, owdk_rate_stage and owdk_cubic.
module omni_wheel_drive_kinematics_top import owdk_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  owdk_cmd_if.sink      in_cmd,
  owdk_drive_if.source  out_drv
);

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES:0]   en;
  stage_ctl_t            ctl;

  rev_t                  x_s2 [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] zero_s2;
  logic                  bad_s2;
  logic [3:0]            bad_pipe_r;
  drive_t                drive [NUM_WHEELS];
  logic                  in_fire, out_fire;

  // Ready ripples back from the output through full stages; an empty stage is always ready.
  always_comb begin
    en[NUM_STAGES] = out_drv.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt[0] = en[0] ? in_cmd.valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  assign ctl.load_rate   = en[0];
  assign ctl.load_scale  = en[1];
  assign ctl.load_square = en[2];
  assign ctl.load_cube   = en[3];
  assign ctl.load_terms  = en[4];
  assign ctl.load_sum    = en[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  owdk_rate_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rate (
    .clk        (clk),
    .ctl        (ctl),
    .velocity_x (in_cmd.velocity_x),
    .velocity_y (in_cmd.velocity_y),
    .turn_rate  (in_cmd.turn_rate),
    .x_r        (x_s2),
    .zero_r     (zero_s2),
    .bad_r      (bad_s2)
  );

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
    owdk_cubic u_cubic (
      .clk     (clk),
      .ctl     (ctl),
      .x_in    (x_s2[i]),
      .zero_in (zero_s2[i]),
      .drive_r (drive[i])
    );
  end

  // The infeasible flag rides alongside the wheel stages.
  always_ff @(posedge clk) begin
    if (en[2]) bad_pipe_r[0] <= bad_s2;
    if (en[3]) bad_pipe_r[1] <= bad_pipe_r[0];
    if (en[4]) bad_pipe_r[2] <= bad_pipe_r[1];
    if (en[5]) bad_pipe_r[3] <= bad_pipe_r[2];
  end

  assign in_cmd.ready              = en[0];
  assign out_drv.valid             = valid_r[NUM_STAGES-1];
  assign out_drv.wheel_one_drive   = drive[0];
  assign out_drv.wheel_two_drive   = drive[1];
  assign out_drv.wheel_three_drive = drive[2];
  assign out_drv.infeasible        = bad_pipe_r[3];

  assign in_fire  = in_cmd.valid && in_cmd.ready;
  assign out_fire = out_drv.valid && out_drv.ready;

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_drv.valid && out_drv.infeasible) |->
      (out_drv.wheel_one_drive == '0 && out_drv.wheel_two_drive == '0 &&
       out_drv.wheel_three_drive == '0))
    else $error("infeasible item with nonzero drive");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_cmd.ready |-> (&valid_r))
    else $error("input stalled while a stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> valid_r[0])
    else $error("accepted item did not enter the first stage");

  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && !out_fire) |=> ($countones(valid_r) == $past($countones(valid_r))))
    else $error("item lost or duplicated in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_drv.valid)
    else $error("result valid right after reset");

endmodule

// ===== verif/omni_wheel_drive_kinematics_top_tb.sv =====
// Testbench for omni_wheel_drive_kinematics_top: sends body velocity items and checks each
// result against a predictor of the wheel drive values written in SystemVerilog.
// Depends on owdk_pkg, owdk_cmd_if, owdk_drive_if and the RTL of the block.
module omni_wheel_drive_kinematics_top_tb import owdk_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC = 12;
  localparam longint RATE_LIM = longint'(60) << FRAC;
  localparam longint REV_PER_RATE = 68356528;
  localparam longint SERVO_A = 2608680;
  localparam longint SERVO_B = 826298;
  localparam longint SERVO_C = 1449637;
  localparam longint SERVO_D = 8416539;
  localparam int     MAX_PRINTED = 50;

  typedef logic signed [IN_W-1:0] vel_t;

  typedef struct packed {
    drive_t one;
    drive_t two;
    drive_t three;
    logic   infeasible;
  } wheel_drives_t;

  logic clk = 1'b0;
  logic rst_n;
  logic full_rate = 1'b0;
  int   mismatches;

  wheel_drives_t pending_drives[$];

  owdk_cmd_if   cmd_ch();
  owdk_drive_if drv_ch();

  omni_wheel_drive_kinematics_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch),
    .out_drv (drv_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wheel rate in units of 1/(10 * 2^FRAC) rad/s mapped to a servo value.
  function automatic drive_t servo_value(longint rate);
    longint rev, rev2, rev3, poly, level;
    if (rate >= RATE_LIM || rate <= -RATE_LIM) return '0;
    rev = (rate * REV_PER_RATE) >>> (FRAC + 8);
    rev2 = (rev * rev) >>> 24;
    rev3 = (rev2 * rev) >>> 24;
    poly = SERVO_A * rev3 - SERVO_B * rev2 + SERVO_C * rev + (SERVO_D <<< 24);
    level = poly >>> 40;
    if (level < 0) return '0;
    if (level > 255) return 8'd255;
    return drive_t'(level);
  endfunction

  function automatic wheel_drives_t predict_drives(vel_t vx, vel_t vy, vel_t w);
    longint rate [3];
    wheel_drives_t res;
    logic over;
    rate[0] = -500 * longint'(vx) + 45 * longint'(w);
    rate[1] = 250 * longint'(vx) - 433 * longint'(vy) + 45 * longint'(w);
    rate[2] = 433 * longint'(vx) + 250 * longint'(vy) + 45 * longint'(w);
    over = 1'b0;
    for (int i = 0; i < 3; i++)
      if (rate[i] > RATE_LIM || rate[i] < -RATE_LIM) over = 1'b1;
    res.infeasible = over;
    res.one = over ? '0 : servo_value(rate[0]);
    res.two = over ? '0 : servo_value(rate[1]);
    res.three = over ? '0 : servo_value(rate[2]);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Drives one item and waits for it to be taken; the expectation is queued at that edge.
  task automatic send_cmd(input vel_t vx, input vel_t vy, input vel_t w);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.velocity_x <= vx;
    cmd_ch.velocity_y <= vy;
    cmd_ch.turn_rate <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_drives.push_back(predict_drives(vx, vy, w));
  endtask

  function automatic vel_t rand_vel(int span);
    return vel_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Searches a command that puts one wheel at the given rate exactly and sends it.
  task automatic send_wheel_at_rate(input int wheel, input longint target);
    longint dot, num, wl;
    logic found;
    vel_t vx, vy, w;
    wheel_drives_t res;
    found = 1'b0;
    for (int a = -200; a <= 200 && !found; a++) begin
      for (int b = -200; b <= 200 && !found; b++) begin
        case (wheel)
          0: dot = -500 * longint'(a);
          1: dot = 250 * longint'(a) - 433 * longint'(b);
          default: dot = 433 * longint'(a) + 250 * longint'(b);
        endcase
        num = target - dot;
        if (num % 45 == 0) begin
          wl = num / 45;
          if (wl >= -32768 && wl <= 32767) begin
            vx = vel_t'(a);
            vy = vel_t'(b);
            w = vel_t'(wl);
            res = predict_drives(vx, vy, w);
            if (res.infeasible == (target > RATE_LIM || target < -RATE_LIM)) found = 1'b1;
          end
        end
      end
    end
    if (found) send_cmd(vx, vy, w);
    else report_mismatch($sformatf("no command found for wheel %0d at rate %0d", wheel, target));
  endtask

  task automatic test_extremes;
    send_cmd(16'sd0, 16'sd0, 16'sd0);
    send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_cmd(16'sh7fff, 16'sd0, 16'sd0);
    send_cmd(16'sh8000, 16'sd0, 16'sd0);
    send_cmd(16'sd0, 16'sh7fff, 16'sd0);
    send_cmd(16'sd0, 16'sh8000, 16'sd0);
    send_cmd(16'sd0, 16'sd0, 16'sh7fff);
    send_cmd(16'sd0, 16'sd0, 16'sh8000);
    send_cmd(16'sd1, -16'sd1, 16'sd1);
    send_cmd(16'sd100, -16'sd100, 16'sd1000);
  endtask

  // Each wheel exactly at plus and minus six rad/s, then just beyond the limit.
  task automatic test_rate_limits;
    for (int k = 0; k < 3; k++) begin
      send_wheel_at_rate(k, RATE_LIM);
      send_wheel_at_rate(k, -RATE_LIM);
    end
    send_wheel_at_rate(0, RATE_LIM + 5);
    send_wheel_at_rate(1, RATE_LIM + 1);
    send_wheel_at_rate(2, -RATE_LIM - 1);
  endtask

  task automatic send_random_cmd;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2)
      send_cmd(vel_t'($urandom), vel_t'($urandom), vel_t'($urandom));
    else if (pick < 8)
      send_cmd(rand_vel(250), rand_vel(250), rand_vel(2000));
    else
      send_cmd(rand_vel(500), rand_vel(500), rand_vel(5000));
  endtask

  task automatic test_full_rate;
    full_rate = 1'b1;
    repeat (150) send_random_cmd();
    full_rate = 1'b0;
  endtask

  task automatic test_random;
    for (int n = 0; n < 1400; n++) begin
      if (n % 64 == 0) full_rate = ($urandom_range(0, 4) == 0);
      send_random_cmd();
    end
    full_rate = 1'b0;
  endtask

  // Result side: a random stall before each item, none while full_rate is set.
  initial begin
    int stall;
    forever begin
      stall = full_rate ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        drv_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      drv_ch.ready <= 1'b1;
      do @(posedge clk); while (!(drv_ch.valid && drv_ch.ready));
    end
  end

  always @(posedge clk) begin
    wheel_drives_t want;
    if (rst_n && drv_ch.valid && drv_ch.ready) begin
      if (pending_drives.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_drives.pop_front();
        if (drv_ch.wheel_one_drive !== want.one)
          report_mismatch($sformatf("wheel_one_drive %0d, expected %0d",
                                    drv_ch.wheel_one_drive, want.one));
        if (drv_ch.wheel_two_drive !== want.two)
          report_mismatch($sformatf("wheel_two_drive %0d, expected %0d",
                                    drv_ch.wheel_two_drive, want.two));
        if (drv_ch.wheel_three_drive !== want.three)
          report_mismatch($sformatf("wheel_three_drive %0d, expected %0d",
                                    drv_ch.wheel_three_drive, want.three));
        if (drv_ch.infeasible !== want.infeasible)
          report_mismatch($sformatf("infeasible %0b, expected %0b",
                                    drv_ch.infeasible, want.infeasible));
      end
    end
  end

  initial begin
    mismatches = 0;
    full_rate = 1'b0;
    rst_n <= 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.velocity_x <= '0;
    cmd_ch.velocity_y <= '0;
    cmd_ch.turn_rate <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_rate_limits();
    test_full_rate();
    test_random();

    cmd_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_drives.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
